// ----- src/rqld_pkg.sv -----
`default_nettype none

package rqld_pkg;

    // Directory geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Field widths
    localparam int KEY_W = 64;
    localparam int CAP_W = 5;
    localparam int CTR_W = 32;

    // Compare width for occupancy against capacity
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Stream payload widths
    localparam int IN_W        = 2 * KEY_W;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = 1 + IDX_W + 1 + 2 * CTR_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [ENTRIES-1:0] t_vec;

    typedef struct packed {
        logic [KEY_W-1:0] range_end;
        logic [KEY_W-1:0] range_start;
    } t_key;

    typedef struct packed {
        logic hit;
        logic evict;
        t_idx slot;
    } t_decision;

endpackage

`default_nettype wire

// ----- src/rqld_cam.sv -----
`default_nettype none

module rqld_cam
    import rqld_pkg::*;
(
    input  wire logic i_clk,
    input  wire t_key i_key,
    input  wire t_vec i_valid,
    input  wire logic i_wr_en,
    input  wire t_idx i_wr_slot,
    output t_vec      o_match
);

    logic [KEY_W-1:0] r_key_start [ENTRIES];
    logic [KEY_W-1:0] r_key_end   [ENTRIES];

    // Write the query key into the chosen entry on a miss
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_key_start[i_wr_slot] <= i_key.range_start;
            r_key_end[i_wr_slot]   <= i_key.range_end;
        end
    end

    // Compare against every entry in parallel
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            o_match[i] = i_valid[i] && (r_key_start[i] == i_key.range_start)
                                    && (r_key_end[i] == i_key.range_end);
        end
    end

endmodule

`default_nettype wire

// ----- src/rqld_lru.sv -----
`default_nettype none

module rqld_lru
    import rqld_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CAP_W-1:0] i_capacity,
    input  wire t_vec             i_match,
    input  wire logic             i_go,
    output t_decision             o_dec,
    output t_vec                  o_valid
);

    t_vec             r_valid;
    t_idx             r_rank [ENTRIES];
    logic [CNT_W-1:0] r_occ;

    logic             hit;
    logic             full;
    t_idx             hit_idx;
    t_idx             hit_rank;
    t_idx             free_idx;
    t_idx             victim_idx;
    t_idx             lru_rank;
    t_idx             slot;
    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] eff_cap;
    logic [CMP_W-1:0] occ_ext;
    t_vec             age;

    // Clamp capacity into 1..ENTRIES
    always_comb begin
        cap_ext = CMP_W'(i_capacity);
        occ_ext = CMP_W'(r_occ);
        if (cap_ext == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
        full = occ_ext >= eff_cap;
    end

    // Ranks of valid entries form a permutation of 0..occ-1, so the LRU
    // entry is the one whose rank is occ-1.
    assign lru_rank = IDX_W'(r_occ - CNT_W'(1));

    always_comb begin
        hit        = |i_match;
        hit_idx    = '0;
        hit_rank   = '0;
        free_idx   = '0;
        victim_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (i_match[i]) begin
                hit_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
            end
            if (r_valid[i] && (r_rank[i] == lru_rank)) begin
                victim_idx = IDX_W'(i);
            end
        end
        for (int i = 0; i < ENTRIES; i++) begin
            hit_rank = hit_rank | (i_match[i] ? r_rank[i] : '0);
        end
    end

    always_comb begin
        if (hit) begin
            slot = hit_idx;
        end else if (full) begin
            slot = victim_idx;
        end else begin
            slot = free_idx;
        end
    end

    // Age every valid entry that was more recent than the one promoted
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit) begin
                age[i] = r_valid[i] && (r_rank[i] < hit_rank);
            end else if (full) begin
                age[i] = r_valid[i] && (r_rank[i] < lru_rank);
            end else begin
                age[i] = r_valid[i];
            end
            if (IDX_W'(i) == slot) begin
                age[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_go) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (IDX_W'(i) == slot) begin
                    r_rank[i] <= '0;
                end else if (age[i]) begin
                    r_rank[i] <= r_rank[i] + IDX_W'(1);
                end
            end
            if (!hit && !full) begin
                r_valid[slot] <= 1'b1;
                r_occ         <= r_occ + CNT_W'(1);
            end
        end
    end

    assign o_dec.hit   = hit;
    assign o_dec.evict = !hit && full;
    assign o_dec.slot  = slot;
    assign o_valid     = r_valid;

endmodule

`default_nettype wire

// ----- src/range_query_lru_directory_core.sv -----
// Fully associative LRU directory keyed by a (range_start, range_end) pair.
// Each query on the slave stream is compared against every held entry at
// once; a hit promotes the entry to most recently used, a miss writes the key
// into the lowest free entry or, once occupancy reaches the capacity register
// (0 reads as 1, values above the entry count read as the entry count), over
// the least recently used entry. Each query gives one result transaction with
// hit, slot, evicted and saturating hit/miss totals. Throughput is one query
// per clock while results are taken: a query is held in the input register
// while the parallel compare and rank update run, then lands in the result
// register, which drives o_m_tvalid. A stalled result holds the pipeline;
// capacity may only be written while the block is idle.
// No clearing pass follows reset: entry valid bits clear at once.
`default_nettype none

module range_query_lru_directory_core
    import rqld_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Query stream
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // tdata: range_start [63:0], range_end [127:64]
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    // Result stream
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // tdata: hit, slot, evicted, hit_total, miss_total (lowest bit up)
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    // Capacity write channel
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CAP_W-1:0]       i_cfg_data
);

    logic             r_in_valid;
    t_key             r_in_key;
    logic             r_out_valid;
    t_decision        r_out_dec;
    logic [CTR_W-1:0] r_hit_total;
    logic [CTR_W-1:0] r_miss_total;
    logic [CAP_W-1:0] r_capacity;

    logic             advance;
    t_vec             match;
    t_vec             valid;
    t_decision        dec;

    // Advance the query into the result register when that register frees up
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_key.range_start <= i_s_tdata[KEY_W-1:0];
            r_in_key.range_end   <= i_s_tdata[2*KEY_W-1:KEY_W];
        end
    end

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    rqld_cam u_cam (
        .i_clk     (i_clk),
        .i_key     (r_in_key),
        .i_valid   (valid),
        .i_wr_en   (advance && !dec.hit),
        .i_wr_slot (dec.slot),
        .o_match   (match)
    );

    rqld_lru u_lru (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_capacity (r_capacity),
        .i_match    (match),
        .i_go       (advance),
        .o_dec      (dec),
        .o_valid    (valid)
    );

    // Result register; the totals only move when a result is loaded, so they
    // double as the output fields.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_hit_total  <= '0;
            r_miss_total <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                if (dec.hit) begin
                    if (r_hit_total != '1) begin
                        r_hit_total <= r_hit_total + CTR_W'(1);
                    end
                end else begin
                    if (r_miss_total != '1) begin
                        r_miss_total <= r_miss_total + CTR_W'(1);
                    end
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_dec <= dec;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'({r_miss_total, r_hit_total, r_out_dec.evict,
                                      r_out_dec.slot, r_out_dec.hit});

endmodule

`default_nettype wire

// ----- src/rqld_checker.sv -----
`default_nettype none

module rqld_checker
    import rqld_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_tvalid,
    input wire logic                   o_s_tready,
    input wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    input wire logic                   o_m_tvalid,
    input wire logic                   i_m_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_tdata,
    input wire logic                   i_cfg_valid,
    input wire logic                   o_cfg_ready,
    input wire logic [CAP_W-1:0]       i_cfg_data
);

    localparam int HIT_LO  = IDX_W + 2;
    localparam int MISS_LO = HIT_LO + CTR_W;

    logic             out_hit;
    logic             out_evict;
    logic [CTR_W-1:0] out_hits;
    logic [CTR_W-1:0] out_misses;
    logic             out_xfer;
    logic             r_seen;
    logic [CTR_W-1:0] r_last_hits;
    logic [CTR_W-1:0] r_last_misses;

    assign out_hit    = o_m_tdata[0];
    assign out_evict  = o_m_tdata[IDX_W+1];
    assign out_hits   = o_m_tdata[HIT_LO+CTR_W-1:HIT_LO];
    assign out_misses = o_m_tdata[MISS_LO+CTR_W-1:MISS_LO];
    assign out_xfer   = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen        <= 1'b0;
            r_last_hits   <= '0;
            r_last_misses <= '0;
        end else if (out_xfer) begin
            r_seen        <= 1'b1;
            r_last_hits   <= out_hits;
            r_last_misses <= out_misses;
        end
    end

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |-> !(out_hit && out_evict))
        else $error("hit result reports an eviction");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_totals_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && r_seen) |->
            (out_hit ?
                ((out_hits == ((r_last_hits == '1) ? r_last_hits : r_last_hits + CTR_W'(1)))
                 && (out_misses == r_last_misses)) :
                ((out_misses == ((r_last_misses == '1) ? r_last_misses
                                                       : r_last_misses + CTR_W'(1)))
                 && (out_hits == r_last_hits))))
        else $error("hit or miss total did not step by one");

endmodule

bind range_query_lru_directory_core rqld_checker u_rqld_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .i_s_tdata   (i_s_tdata),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_data  (i_cfg_data)
);

`default_nettype wire

// ----- tb/sv/lru_directory_checker.sv -----
module lru_directory_checker
    import rqld_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    input  wire logic                   i_s_tready,
    // tdata: range_start [63:0], range_end [127:64]
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  wire logic                   i_m_tvalid,
    input  wire logic                   i_m_tready,
    // tdata: hit, slot, evicted, hit_total, miss_total (lowest bit up)
    input  wire logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  wire logic                   i_cfg_valid,
    input  wire logic                   i_cfg_ready,
    input  wire logic [CAP_W-1:0]       i_cfg_data,
    output int                          o_error_count,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Packed so that hit lands in bit 0, as on the result bus.
    typedef struct packed {
        logic [CTR_W-1:0] miss_total;
        logic [CTR_W-1:0] hit_total;
        logic             evicted;
        t_idx             slot;
        logic             hit;
    } lookup_result_t;

    logic [KEY_W-1:0] held_start [ENTRIES];
    logic [KEY_W-1:0] held_end   [ENTRIES];
    logic             held_valid [ENTRIES];
    t_idx             age_rank   [ENTRIES];
    logic [CNT_W-1:0] occupancy;
    logic [CTR_W-1:0] hits_seen;
    logic [CTR_W-1:0] misses_seen;
    logic [CAP_W-1:0] capacity;
    lookup_result_t   expected_lookups [$];
    int               errors = 0;

    // Age every held entry ranked below the limit, then make idx the newest.
    function automatic void make_recent(input t_idx idx, input int limit);
        for (int i = 0; i < ENTRIES; i++) begin
            if (i != idx && held_valid[i] && age_rank[i] < limit)
                age_rank[i] = age_rank[i] + 1'b1;
        end
        age_rank[idx] = '0;
    endfunction

    function automatic lookup_result_t predict_lookup(input t_key key);
        lookup_result_t res;
        int             cap_eff;
        int             oldest;
        logic           found;
        res    = '0;
        oldest = 0;
        found  = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!res.hit && held_valid[i] && held_start[i] == key.range_start
                    && held_end[i] == key.range_end) begin
                res.hit  = 1'b1;
                res.slot = t_idx'(i);
            end
        end
        if (res.hit) begin
            make_recent(res.slot, age_rank[res.slot]);
            if (hits_seen != '1)
                hits_seen = hits_seen + 1'b1;
        end else begin
            if (misses_seen != '1)
                misses_seen = misses_seen + 1'b1;
            // zero reads as one, anything past the entry count as the entry count
            cap_eff = (capacity == 0) ? 1 : (capacity > ENTRIES) ? ENTRIES : capacity;
            if (occupancy >= cap_eff) begin
                // replace the single oldest entry, even when over capacity
                for (int i = 0; i < ENTRIES; i++) begin
                    if (held_valid[i] && (!found || age_rank[i] > oldest)) begin
                        oldest   = age_rank[i];
                        res.slot = t_idx'(i);
                        found    = 1'b1;
                    end
                end
                res.evicted = 1'b1;
                make_recent(res.slot, oldest);
            end else begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!found && !held_valid[i]) begin
                        res.slot = t_idx'(i);
                        found    = 1'b1;
                    end
                end
                make_recent(res.slot, ENTRIES);
                held_valid[res.slot] = 1'b1;
                occupancy = occupancy + 1'b1;
            end
            held_start[res.slot] = key.range_start;
            held_end[res.slot]   = key.range_end;
        end
        res.hit_total  = hits_seen;
        res.miss_total = misses_seen;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        lookup_result_t got;
        lookup_result_t want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                held_valid[i] = 1'b0;
                age_rank[i]   = '0;
                held_start[i] = '0;
                held_end[i]   = '0;
            end
            occupancy   = '0;
            hits_seen   = '0;
            misses_seen = '0;
            capacity    = CAP_RESET;
            expected_lookups.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                capacity = i_cfg_data;
            if (i_m_tvalid && i_m_tready) begin
                got = lookup_result_t'(i_m_tdata[OUT_W-1:0]);
                if (expected_lookups.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, i_m_tdata);
                end else begin
                    want = expected_lookups.pop_front();
                    check_field("hit", 64'(want.hit), 64'(got.hit));
                    check_field("slot", 64'(want.slot), 64'(got.slot));
                    check_field("evicted", 64'(want.evicted), 64'(got.evicted));
                    check_field("hit_total", 64'(want.hit_total), 64'(got.hit_total));
                    check_field("miss_total", 64'(want.miss_total), 64'(got.miss_total));
                    check_field("tdata padding", '0, 64'(i_m_tdata >> OUT_W));
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_lookups.push_back(predict_lookup(t_key'(i_s_tdata[IN_W-1:0])));
        end
        o_pending     = expected_lookups.size();
        o_error_count = errors;
    end

endmodule

// ----- tb/sv/tb_range_query_lru_directory_core.sv -----
module tb_range_query_lru_directory_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rqld_pkg::*;

    localparam int RUN_LIMIT     = 1_000_000;  // cycles before the run is abandoned
    localparam int LONG_HOLD     = 300;        // result-side hold-off that backs up the block
    localparam int PHASE_QUERIES = 200;
    localparam int POOL_SIZE     = 32;         // keys that random phases recycle for hits
    localparam int SETTLE_CYCLES = 4;          // input and result registers plus margin

    // All block inputs start at known values; after that they only change
    // by nonblocking assignment right after a rising edge.
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_s_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                   i_m_tready  = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [CAP_W-1:0]       i_cfg_data  = '0;
    wire logic              o_s_tready;
    wire logic              o_m_tvalid;
    wire logic [OUT_TDATA_W-1:0] o_m_tdata;
    wire logic              o_cfg_ready;

    int   error_count;
    int   pending;
    int   cycle_count     = 0;
    int   queries_sent    = 0;
    int   capacity_writes = 0;
    int   long_holds      = 0;
    bit   hold_request    = 1'b0;
    t_key key_pool [POOL_SIZE];

    always #1 i_clk = ~i_clk;

    range_query_lru_directory_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Scoreboard: predicts every accepted query and checks each result transaction.
    lru_directory_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    // Watchdog: a stuck handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result sink: ready in bursts of random length. Mostly short stalls,
    // a few long ones, and long ready stretches so back-to-back results get
    // through. A hold request from the stimulus side turns into one long
    // stall counted here.
    initial begin : result_sink
        int   pick;
        int   span;
        logic level;
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                level        = 1'b0;
                span         = LONG_HOLD;
                hold_request = 1'b0;
                long_holds++;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    level = 1'b1;
                    span  = $urandom_range(1, 8);
                end else if (pick < 60) begin
                    level = 1'b1;
                    span  = $urandom_range(20, 80);
                end else if (pick < 90) begin
                    level = 1'b0;
                    span  = $urandom_range(1, 3);
                end else begin
                    level = 1'b0;
                    span  = $urandom_range(15, 50);
                end
            end
            i_m_tready <= level;
            repeat (span) @(posedge i_clk);
        end
    end

    function automatic t_key make_key(input logic [KEY_W-1:0] from_ts,
                                      input logic [KEY_W-1:0] end_ts);
        t_key k;
        k.range_start = from_ts;
        k.range_end   = end_ts;
        return k;
    endfunction

    function automatic t_key random_key();
        return make_key({$urandom, $urandom}, {$urandom, $urandom});
    endfunction

    // Sender idle length: mostly none or short, now and then long.
    function automatic int sender_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Offer one query and hold it until the block takes it. Ready is sampled
    // on the falling edge, where nothing is moving, so the acceptance decision
    // matches what the block sees at the next rising edge. Valid stays high on
    // return so back-to-back queries never drop it.
    task automatic send_query(input t_key key, input bit allow_gaps);
        int   gap;
        logic accepted;
        gap = allow_gaps ? sender_gap() : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= key;
        do begin
            @(negedge i_clk);
            accepted = o_s_tready;
            @(posedge i_clk);
        end while (!accepted);
        queries_sent++;
    endtask

    // Drop valid, wait for every outstanding result, then let the pipeline settle.
    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Capacity is only written with the block idle.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        logic accepted;
        wait_for_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do begin
            @(negedge i_clk);
            accepted = o_cfg_ready;
            @(posedge i_clk);
        end while (!accepted);
        i_cfg_valid <= 1'b0;
        capacity_writes++;
    endtask

    // One random phase: most queries reuse a working set sized around the
    // capacity so hits, fills and evictions all happen; the rest are fresh
    // keys and near misses with a single bit flipped in start or end.
    task automatic run_phase(input logic [CAP_W-1:0] cap, input bit allow_gaps,
                             input bit stall_sink, input bit pause_midway);
        int   cap_eff;
        int   span;
        int   pick;
        t_key key;
        write_capacity(cap);
        cap_eff = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : cap;
        span    = cap_eff + $urandom_range(0, 4) - 1;
        if (span < 1)
            span = 1;
        if (span > POOL_SIZE)
            span = POOL_SIZE;
        // keep part of the pool so some hits carry across the capacity change
        for (int p = 0; p < POOL_SIZE; p++) begin
            if ($urandom_range(0, 2) == 0)
                key_pool[p] = random_key();
        end
        if (stall_sink)
            hold_request = 1'b1;
        for (int n = 0; n < PHASE_QUERIES; n++) begin
            if (pause_midway && n == PHASE_QUERIES / 2)
                wait_for_results();
            pick = $urandom_range(0, 99);
            if (pick < 84) begin
                key = key_pool[$urandom_range(0, span - 1)];
            end else if (pick < 94) begin
                key = random_key();
            end else begin
                key = key_pool[$urandom_range(0, span - 1)];
                key = key ^ (t_key'(1) << $urandom_range(0, IN_W - 1));
            end
            // drift the working set slowly
            if ($urandom_range(0, 49) == 0)
                key_pool[$urandom_range(0, span - 1)] = random_key();
            send_query(key, allow_gaps);
        end
    endtask

    initial begin : stimulus
        t_key edge_keys [6];
        t_key repeat_key;

        edge_keys[0] = make_key('0, '0);
        edge_keys[1] = make_key('1, '1);
        edge_keys[2] = make_key('0, '1);
        edge_keys[3] = make_key('1, '0);
        edge_keys[4] = make_key(64'd0, 64'd1);
        edge_keys[5] = make_key(64'd1, 64'd0);
        for (int p = 0; p < POOL_SIZE; p++)
            key_pool[p] = random_key();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extreme keys and keys that match in one half only.
        for (int k = 0; k < 6; k++)
            send_query(edge_keys[k], 1'b1);
        send_query(edge_keys[0], 1'b1);
        send_query(edge_keys[1], 1'b1);
        // fill the directory at reset capacity, then force the first eviction
        for (int k = 0; k < 10; k++)
            send_query(key_pool[k], 1'b1);
        send_query(random_key(), 1'b1);
        send_query(edge_keys[0], 1'b1);

        // Capacity lowered below occupancy: misses replace, occupancy holds.
        write_capacity(CAP_W'(3));
        send_query(random_key(), 1'b0);
        send_query(random_key(), 1'b0);
        send_query(key_pool[9], 1'b0);

        // Capacity zero behaves as one.
        write_capacity('0);
        repeat_key = random_key();
        send_query(random_key(), 1'b1);
        send_query(repeat_key, 1'b1);
        send_query(repeat_key, 1'b1);

        // Random phases across capacity settings, including both extremes and
        // values past the entry count. Two phases back the block up with a
        // long result hold, another pauses the sender until all results are in.
        run_phase(CAP_W'(16), 1'b1, 1'b1, 1'b0);
        run_phase(CAP_W'(1),  1'b1, 1'b0, 1'b0);
        run_phase(CAP_W'(31), 1'b0, 1'b0, 1'b0);
        run_phase(CAP_W'(0),  1'b1, 1'b1, 1'b0);
        run_phase(CAP_W'(17), 1'b1, 1'b0, 1'b1);
        run_phase(CAP_W'(2),  1'b0, 1'b0, 1'b0);
        run_phase(CAP_W'(9),  1'b1, 1'b0, 1'b0);
        run_phase(CAP_W'($urandom_range(0, 31)), 1'b1, 1'b0, 1'b0);

        // Drain; any late result now shows up as unexpected in the checker.
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d range queries under %0d capacity writes (0, 1 and 16 up to 31)",
                 queries_sent, capacity_writes);
        $display("with %0d long result holds, %0d mismatches, %0d results left unmatched",
                 long_holds, error_count, pending);
        if (error_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
